// ----- src/pulse_rate_band_indicator_macros.svh -----
// Assertion macros shared by the pulse rate band indicator modules.
`ifndef PULSE_RATE_BAND_INDICATOR_MACROS_SVH
`define PULSE_RATE_BAND_INDICATOR_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define PRBI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property that also holds while reset is asserted.
`define PRBI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/prbi_pkg.sv -----
// Package with the shared types and constants of the pulse rate band indicator.
package prbi_pkg;

    localparam int REG_W = 12;
    localparam int IDX_W = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] IDX_LOW_MIN    = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LOW_MAX    = 3'd1;
    localparam logic [IDX_W-1:0] IDX_HIGH_MIN   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_HIGH_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_BLINK_PER  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_SILENCE_TO = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] RST_LOW_MIN    = 12'd200;
    localparam logic [REG_W-1:0] RST_LOW_MAX    = 12'd500;
    localparam logic [REG_W-1:0] RST_HIGH_MIN   = 12'd143;
    localparam logic [REG_W-1:0] RST_HIGH_MAX   = 12'd199;
    localparam logic [REG_W-1:0] RST_BLINK_PER  = 12'd167;
    localparam logic [REG_W-1:0] RST_SILENCE_TO = 12'd2000;

    // Rate class codes.
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_LOW  = 2'd1;
    localparam logic [1:0] CLASS_HIGH = 2'd2;

    typedef struct packed {
        logic [REG_W-1:0] low_band_min;
        logic [REG_W-1:0] low_band_max;
        logic [REG_W-1:0] high_band_min;
        logic [REG_W-1:0] high_band_max;
        logic [REG_W-1:0] blink_period;
        logic [REG_W-1:0] silence_timeout;
    } cfg_t;

    typedef struct packed {
        logic       indicator_drive;
        logic [1:0] rate_class;
    } result_t;

endpackage

// ----- src/prbi_cfg_regs.sv -----
// Configuration register bank of the pulse rate band indicator.
module prbi_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [prbi_pkg::IDX_W-1:0] cfg_index,
    input  logic [prbi_pkg::REG_W-1:0] cfg_data,
    output prbi_pkg::cfg_t             cfg
);
    import prbi_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                IDX_LOW_MIN:    cfg_next.low_band_min    = cfg_data;
                IDX_LOW_MAX:    cfg_next.low_band_max    = cfg_data;
                IDX_HIGH_MIN:   cfg_next.high_band_min   = cfg_data;
                IDX_HIGH_MAX:   cfg_next.high_band_max   = cfg_data;
                IDX_BLINK_PER:  cfg_next.blink_period    = cfg_data;
                IDX_SILENCE_TO: cfg_next.silence_timeout = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_band_min    <= RST_LOW_MIN;
            cfg_reg.low_band_max    <= RST_LOW_MAX;
            cfg_reg.high_band_min   <= RST_HIGH_MIN;
            cfg_reg.high_band_max   <= RST_HIGH_MAX;
            cfg_reg.blink_period    <= RST_BLINK_PER;
            cfg_reg.silence_timeout <= RST_SILENCE_TO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/prbi_classifier.sv -----
// Interval counter, band classification and indicator blink logic.
module prbi_classifier #(
    parameter int COUNT_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pin_level,
    input  prbi_pkg::cfg_t    cfg,
    output prbi_pkg::result_t result
);
    import prbi_pkg::*;

    `include "pulse_rate_band_indicator_macros.svh"

    localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  prev_reg;
    logic                  prev_next;
    logic [COUNT_BITS-1:0] interval_reg;
    logic [COUNT_BITS-1:0] interval_next;
    logic [1:0]            class_reg;
    logic [1:0]            class_next;
    logic [COUNT_BITS-1:0] blink_reg;
    logic [COUNT_BITS-1:0] blink_next;
    logic                  phase_reg;
    logic                  phase_next;
    logic                  ind_reg;
    logic                  ind_next;

    logic [COUNT_BITS-1:0] interval_inc;
    logic [CMP_W-1:0]      interval_wide;
    logic [CMP_W-1:0]      timeout_wide;
    logic [COUNT_BITS-1:0] blink_inc;
    logic                  falling;

    // Both counters stop at their top value instead of wrapping.
    assign interval_inc = (interval_reg == CNT_MAX) ? CNT_MAX : interval_reg + 1'b1;
    assign blink_inc    = (blink_reg == CNT_MAX) ? CNT_MAX : blink_reg + 1'b1;
    assign falling      = prev_reg && !pin_level;
    assign timeout_wide = CMP_W'(cfg.silence_timeout);

    always_comb
    begin
        prev_next     = pin_level;
        interval_next = interval_inc;
        class_next    = class_reg;
        blink_next    = blink_reg;
        phase_next    = phase_reg;
        ind_next      = ind_reg;

        // A falling edge closes the interval; the low band is tested first.
        if (falling)
        begin
            if ((CMP_W'(interval_inc) >= CMP_W'(cfg.low_band_min)) &&
                (CMP_W'(interval_inc) <= CMP_W'(cfg.low_band_max)))
            begin
                class_next = CLASS_LOW;
            end
            else if ((CMP_W'(interval_inc) >= CMP_W'(cfg.high_band_min)) &&
                     (CMP_W'(interval_inc) <= CMP_W'(cfg.high_band_max)))
            begin
                class_next = CLASS_HIGH;
            end
            else
            begin
                class_next = CLASS_NONE;
            end
            interval_next = '0;
        end

        // Silence: the class drops and the counter parks at the timeout.
        interval_wide = CMP_W'(interval_next);
        if (interval_wide >= timeout_wide)
        begin
            class_next    = CLASS_NONE;
            interval_next = timeout_wide[COUNT_BITS-1:0];
        end

        if (class_next == CLASS_HIGH)
        begin
            blink_next = blink_inc;
            if (CMP_W'(blink_inc) >= CMP_W'(cfg.blink_period))
            begin
                blink_next = '0;
                phase_next = !phase_reg;
                ind_next   = !phase_reg;
            end
        end
        else
        begin
            ind_next   = (class_next == CLASS_LOW) ? 1'b0 : 1'b1;
            blink_next = '0;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= 1'b1;
            interval_reg <= '0;
            class_reg    <= CLASS_NONE;
            blink_reg    <= '0;
            phase_reg    <= 1'b0;
            ind_reg      <= 1'b1;
        end
        else if (step)
        begin
            prev_reg     <= prev_next;
            interval_reg <= interval_next;
            class_reg    <= class_next;
            blink_reg    <= blink_next;
            phase_reg    <= phase_next;
            ind_reg      <= ind_next;
        end
    end

    assign result.indicator_drive = ind_next;
    assign result.rate_class      = class_next;

    `PRBI_ASSERT(a_low_is_lit, (class_reg == CLASS_LOW) |-> !ind_reg, "low band but indicator dark")
    `PRBI_ASSERT(a_none_is_dark, (class_reg == CLASS_NONE) |-> (ind_reg && !phase_reg),
                 "no class but indicator lit or phase set")
    `PRBI_ASSERT(a_blink_idle, (class_reg != CLASS_HIGH) |-> (blink_reg == '0),
                 "blink counter running outside high band")
    `PRBI_ASSERT(a_hold_state, !step |=> ($stable(interval_reg) && $stable(class_reg)),
                 "state changed without a tick")

endmodule

// ----- src/pulse_rate_band_indicator.sv -----
// Top level of the pulse rate band indicator: handshake stages and submodules.
//
// The block classifies the rate of falling edges on a sampled signal pin.
// Each request on the slave stream (s_tvalid/s_tready/s_tdata) is one
// one-millisecond tick carrying the pin level in s_tdata bit 0. Every tick
// produces exactly one request on the master stream (m_tvalid/m_tready/
// m_tdata) with the indicator pin level and the current rate class.
// The interval since the last falling edge is compared against the low and
// high band windows; the class falls back to none after the silence timeout.
// Band limits, blink period and timeout are written through cfg_we, cfg_index
// and cfg_data; unknown indexes are ignored. The user must write them only
// while the block is idle; the block itself does not enforce this.
// The tick is held in the input register until the pipeline advances; its result
// is then loaded into the result register, which raises m_tvalid.
// Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// takes one more tick before s_tready drops; no request is lost or repeated.
// Reset clears both stages, puts the registers at their default values,
// the last pin level at high (idle pull-up), the class at none and the
// indicator dark.
module pulse_rate_band_indicator #(
    parameter int COUNT_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] pin_level
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [0] indicator_drive, [2:1] rate_class
    input  logic                       cfg_we,
    input  logic [prbi_pkg::IDX_W-1:0] cfg_index,
    input  logic [prbi_pkg::REG_W-1:0] cfg_data
);
    import prbi_pkg::*;

    `include "pulse_rate_band_indicator_macros.svh"

    cfg_t    cfg;
    result_t result;
    result_t result_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic pin_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic step;
    logic in_accept;

    // The pipeline moves whenever the result slot is empty or being taken.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign step      = in_valid_reg && advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    prbi_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prbi_classifier #(
        .COUNT_BITS (COUNT_BITS)
    ) u_classifier (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pin_level (pin_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on their own handshake events.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pin_reg <= s_tdata[0];
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, result_reg.rate_class, result_reg.indicator_drive};

    `PRBI_ASSERT(a_class_code, m_tvalid |-> (result_reg.rate_class <= CLASS_HIGH),
                 "undefined rate class on output")
    `PRBI_ASSERT(a_no_drop, (in_valid_reg && !advance) |=> in_valid_reg,
                 "stalled tick dropped from input stage")
    `PRBI_ASSERT(a_step_fills, step |=> m_tvalid, "processed tick did not reach the output")

endmodule
